/* sv/lru_range_temperature_table_unit_assert.svh */
// Assertion macros shared by the range temperature table RTL.
`ifndef LRU_RANGE_TEMPERATURE_TABLE_UNIT_ASSERT_SVH
`define LRU_RANGE_TEMPERATURE_TABLE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that holds at every clock edge outside reset
`define LRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`else

`define LRT_ASSERT(lbl, prop, msg)
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/lrt_pkg.sv */
package lrt_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int RANGE_W  = 32;

    // Commands
    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_RAISE = 1'b1;

    // Temperatures
    localparam logic [1:0] TEMP_COLD = 2'd0;
    localparam logic [1:0] TEMP_WARM = 2'd1;
    localparam logic [1:0] TEMP_HOT  = 2'd2;

    // Register map (word index) and reset value
    localparam logic        REG_MAX_SIZE = 1'b0;
    localparam logic [6:0]  MAX_SIZE_RST = 7'd64;

    // Broadcast from the table control to every entry
    typedef struct packed {
        logic               upd;          // raise that changes the table
        logic               hit_any;      // key present somewhere
        logic               do_evict;     // oldest entry leaves on insert
        logic [RANGE_W-1:0] key;
        logic [IDX_W-1:0]   hit_rank;     // rank of the matching entry
        logic [IDX_W-1:0]   oldest_rank;  // occupancy - 1
    } t_entry_ctl;

    // Status of one entry back to the table control
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               hot;
        logic               oldest;
        logic [IDX_W-1:0]   rank;
        logic [RANGE_W-1:0] range_idx;
    } t_entry_stat;

endpackage

/* sv/lrt_cfg.sv */
module lrt_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [lrt_pkg::OCC_W-1:0] o_max_size
);
    import lrt_pkg::*;

    logic [OCC_W-1:0] r_max_size;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_MAX_SIZE);

    // max_size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RST;
        end else if (w_wr) begin
            r_max_size <= pwdata[OCC_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_SIZE) begin
            prdata = {{(32-OCC_W){1'b0}}, r_max_size};
        end
    end

    assign o_max_size = r_max_size;

endmodule

/* sv/lrt_entry.sv */
module lrt_entry (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lrt_pkg::t_entry_ctl  i_ctl,
    input  logic                 i_ins,
    output lrt_pkg::t_entry_stat o_stat
);
    import lrt_pkg::*;

    logic               r_valid;
    logic               r_hot;
    logic [IDX_W-1:0]   r_rank;
    logic [RANGE_W-1:0] r_range;
    logic               w_hit;
    logic               w_oldest;
    logic               w_evict_me;

    // tag compare and age check
    assign w_hit      = r_valid && (r_range == i_ctl.key);
    assign w_oldest   = r_valid && (r_rank == i_ctl.oldest_rank);
    assign w_evict_me = i_ctl.do_evict && w_oldest;

    // control state: valid, hot, rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hot   <= 1'b0;
            r_rank  <= '0;
        end else if (i_ctl.upd) begin
            if (i_ctl.hit_any) begin
                // promote the hit, age the younger ones
                if (w_hit) begin
                    r_rank <= '0;
                    r_hot  <= 1'b1;
                end else if (r_valid && (r_rank < i_ctl.hit_rank)) begin
                    r_rank <= r_rank + IDX_W'(1);
                end
            end else if (i_ins) begin
                r_valid <= 1'b1;
                r_hot   <= 1'b0;
                r_rank  <= '0;
            end else if (w_evict_me) begin
                r_valid <= 1'b0;
                r_hot   <= 1'b0;
                r_rank  <= '0;
            end else if (r_valid) begin
                r_rank <= r_rank + IDX_W'(1);
            end
        end
    end

    // tag payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && !i_ctl.hit_any && i_ins) begin
            r_range <= i_ctl.key;
        end
    end

    always_comb begin
        o_stat.valid     = r_valid;
        o_stat.hit       = w_hit;
        o_stat.hot       = r_hot;
        o_stat.oldest    = w_oldest;
        o_stat.rank      = r_rank;
        o_stat.range_idx = r_range;
    end

endmodule

/* sv/lru_range_temperature_table_unit.sv */
// Range temperature table: a fully associative, least-recently-raised table
// of up to 64 range indices. Each request carries a command in tuser (0
// query, 1 raise) and a range index in tdata; each request yields exactly one
// result {evicted_range, evicted, was_present, temperature}. All 64 tags are
// compared in parallel and the table is updated at the same edge that the
// result is registered, so the unit takes one request per clock cycle while
// the output is not stalled. A result passes through the input register and
// then the result register before it is offered on the output; back-pressure
// on the output stalls the input after one more request. The eviction limit
// max_size is written at APB address 0 and takes effect for the next request;
// write it only when the unit is idle.
`include "lru_range_temperature_table_unit_assert.svh"
module lru_range_temperature_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] range_index
    input  logic [0:0]  i_s_tuser,   // [0] command
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [1:0] temperature, [2] was_present,
                                     // [3] evicted, [35:4] evicted_range
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lrt_pkg::*;

    logic [OCC_W-1:0]   w_max_size;
    logic [OCC_W-1:0]   w_limit;
    logic               w_limit_zero;

    logic               r_in_vld;
    logic               r_in_cmd;
    logic [RANGE_W-1:0] r_in_key;
    logic               w_fire;

    logic               r_out_vld;
    logic [1:0]         r_out_temp;
    logic               r_out_present;
    logic               r_out_evicted;
    logic [RANGE_W-1:0] r_out_ev_range;

    logic [OCC_W-1:0]   r_occ;

    t_entry_ctl         w_ctl;
    t_entry_stat        w_stat [CAPACITY];
    logic [CAPACITY-1:0] w_hit_vec;
    logic [CAPACITY-1:0] w_valid_vec;
    logic [CAPACITY-1:0] w_oldest_vec;
    logic [CAPACITY-1:0] w_free_vec;
    logic [CAPACITY-1:0] w_ins_vec;
    logic               w_hit_any;
    logic               w_hit_hot;
    logic [IDX_W-1:0]   w_hit_rank;
    logic [RANGE_W-1:0] w_oldest_range;
    logic               w_raise;
    logic               w_full;
    logic               w_insert;

    logic [1:0]         n_temp;
    logic               n_evicted;
    logic [RANGE_W-1:0] n_ev_range;

    lrt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_size (w_max_size)
    );

    assign w_limit      = (w_max_size > OCC_W'(CAPACITY)) ? OCC_W'(CAPACITY) : w_max_size;
    assign w_limit_zero = (w_limit == '0);

    // handshake: process when the result register is free or draining
    assign w_fire     = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd <= i_s_tuser[0];
            r_in_key <= i_s_tdata;
        end
    end

    // gather entry status
    always_comb begin
        w_hit_hot      = 1'b0;
        w_hit_rank     = '0;
        w_oldest_range = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_vec[i]    = w_stat[i].hit;
            w_valid_vec[i]  = w_stat[i].valid;
            w_oldest_vec[i] = w_stat[i].oldest;
            w_hit_hot       = w_hit_hot | (w_stat[i].hit & w_stat[i].hot);
            w_hit_rank      = w_hit_rank | (w_stat[i].rank & {IDX_W{w_stat[i].hit}});
            w_oldest_range  = w_oldest_range |
                              (w_stat[i].range_idx & {RANGE_W{w_stat[i].oldest}});
        end
    end

    assign w_hit_any = |w_hit_vec;
    assign w_raise   = (r_in_cmd == CMD_RAISE);
    assign w_full    = (r_occ >= w_limit);
    assign w_insert  = w_fire && w_raise && !w_hit_any && !w_limit_zero;

    // first free slot after the eviction
    assign w_free_vec = ~w_valid_vec | ({CAPACITY{w_full}} & w_oldest_vec);
    assign w_ins_vec  = w_free_vec & (~w_free_vec + CAPACITY'(1));

    // broadcast to entries
    always_comb begin
        w_ctl.upd         = w_fire && w_raise && (w_hit_any || !w_limit_zero);
        w_ctl.hit_any     = w_hit_any;
        w_ctl.do_evict    = w_full;
        w_ctl.key         = r_in_key;
        w_ctl.hit_rank    = w_hit_rank;
        w_ctl.oldest_rank = IDX_W'(r_occ - OCC_W'(1));
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
        lrt_entry u_entry (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_ins   (w_ins_vec[g]),
            .o_stat  (w_stat[g])
        );
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (w_insert) begin
            r_occ <= r_occ + OCC_W'(1) - OCC_W'(w_full);
        end
    end

    // result fields
    always_comb begin
        n_temp     = TEMP_COLD;
        n_evicted  = 1'b0;
        n_ev_range = '0;
        if (w_hit_any) begin
            n_temp = (w_raise || w_hit_hot) ? TEMP_HOT : TEMP_WARM;
        end else if (w_raise) begin
            if (w_limit_zero) begin
                n_evicted  = 1'b1;
                n_ev_range = r_in_key;
            end else begin
                n_temp = TEMP_WARM;
                if (w_full) begin
                    n_evicted  = 1'b1;
                    n_ev_range = w_oldest_range;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_temp     <= n_temp;
            r_out_present  <= w_hit_any;
            r_out_evicted  <= n_evicted;
            r_out_ev_range <= n_ev_range;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0000, r_out_ev_range, r_out_evicted, r_out_present, r_out_temp};

    // checks
    `LRT_ASSERT(a_hit_onehot, $onehot0(w_hit_vec), "more than one entry matches")
    `LRT_ASSERT(a_occ_count, $countones(w_valid_vec) == int'(r_occ), "occupancy out of step")
    `LRT_ASSERT(a_occ_cap, r_occ <= OCC_W'(CAPACITY), "occupancy above capacity")
    `LRT_ASSERT_NEXT(a_raise_hot, w_fire && w_raise && w_hit_any,
        r_out_vld && (r_out_temp == TEMP_HOT) && !r_out_evicted, "raise hit not hot")

endmodule

/* bench/tb_lru_range_temperature_table_unit.sv */
`timescale 1ns / 100ps

module tb_lru_range_temperature_table_unit;

    import lrt_pkg::*;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [2:0]  MAX_SIZE_ADDR  = 3'(4 * REG_MAX_SIZE);

    // One result as it travels in o_m_tdata[35:0]
    typedef struct packed {
        logic [31:0] ev_range;
        logic        evicted;
        logic        was_present;
        logic [1:0]  temp;
    } temp_result_t;

    typedef enum bit [0:0] {ROW_REQ, ROW_CFG} row_kind_t;

    // Directed row: a request or a max_size write; exp used only when typed
    typedef struct packed {
        row_kind_t    kind;
        logic         cmd;
        logic [31:0]  rng;
        logic [6:0]   cfg;
        logic         typed;
        temp_result_t exp;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // empty table after reset
        '{ROW_REQ, CMD_QUERY, 32'h0000_0000, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_COLD}},
        '{ROW_REQ, CMD_QUERY, 32'hFFFF_FFFF, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_COLD}},
        // insert warm, raise again to hot
        '{ROW_REQ, CMD_RAISE, 32'h0000_0000, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_WARM}},
        '{ROW_REQ, CMD_RAISE, 32'h0000_0000, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b1, TEMP_HOT}},
        '{ROW_REQ, CMD_QUERY, 32'h0000_0000, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b1, TEMP_HOT}},
        '{ROW_REQ, CMD_RAISE, 32'hFFFF_FFFF, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_WARM}},
        '{ROW_REQ, CMD_RAISE, 32'h5555_AAAA, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'hAAAA_5555, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_QUERY, 32'hFFFF_FFFF, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b1, TEMP_WARM}},
        // zero limit: an absent range evicts itself, a present one still heats
        '{ROW_CFG, CMD_QUERY, 32'h0000_0000, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'h1234_5678, 7'd0, 1'b1,
          '{32'h1234_5678, 1'b1, 1'b0, TEMP_COLD}},
        '{ROW_REQ, CMD_RAISE, 32'h0000_0000, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b1, TEMP_HOT}},
        '{ROW_REQ, CMD_QUERY, 32'h1234_5678, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_COLD}},
        // limit lowered below occupancy: one eviction per insert
        '{ROW_CFG, CMD_QUERY, 32'h0000_0000, 7'd2, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'hDEAD_BEEF, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'hCAFE_F00D, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_QUERY, 32'hDEAD_BEEF, 7'd0, 1'b0, '0},
        // limit above capacity
        '{ROW_CFG, CMD_QUERY, 32'h0000_0000, 7'd127, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'h8000_0000, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_QUERY, 32'h7FFF_FFFF, 7'd0, 1'b1, '{32'h0, 1'b0, 1'b0, TEMP_COLD}},
        // limit of a single entry
        '{ROW_CFG, CMD_QUERY, 32'h0000_0000, 7'd1, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'h0000_0001, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'h0000_0002, 7'd0, 1'b0, '0},
        '{ROW_REQ, CMD_RAISE, 32'h0000_0002, 7'd0, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;
    logic [0:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    logic [39:0] o_m_tdata;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the table
    logic [31:0] tbl_range [CAPACITY];
    bit          tbl_valid [CAPACITY];
    bit          tbl_hot   [CAPACITY];
    int          tbl_rank  [CAPACITY];
    int          tbl_count;
    logic [6:0]  max_size_q;

    temp_result_t expected_temps [$];
    logic [31:0]  range_pool [$];
    int           mismatch_count;
    int           idle_cycles;
    int           tx_idle_pct;
    int           rx_stall_pct;

    lru_range_temperature_table_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Expected temperature and eviction for one request; updates the shadow
    function automatic temp_result_t compute_temperature(input logic cmd,
                                                         input logic [31:0] rng);
        temp_result_t res;
        int           hit;
        int           lim;
        int           oldest;
        int           free_slot;
        int           hit_rank;
        res = '0;
        hit = -1;
        lim = (max_size_q < CAPACITY) ? int'(max_size_q) : CAPACITY;
        for (int i = 0; i < CAPACITY; i++) begin
            if (tbl_valid[i] && tbl_range[i] == rng) hit = i;
        end
        if (hit >= 0) begin
            res.was_present = 1'b1;
            res.temp        = tbl_hot[hit] ? TEMP_HOT : TEMP_WARM;
        end
        if (cmd == CMD_RAISE) begin
            if (hit >= 0) begin
                // move to newest, everything newer ages by one
                hit_rank = tbl_rank[hit];
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_valid[i] && tbl_rank[i] < hit_rank) tbl_rank[i]++;
                end
                tbl_rank[hit] = 0;
                tbl_hot[hit]  = 1'b1;
                res.temp      = TEMP_HOT;
            end else if (lim == 0) begin
                res.evicted  = 1'b1;
                res.ev_range = rng;
                res.temp     = TEMP_COLD;
            end else begin
                if (tbl_count >= lim) begin
                    oldest = -1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (tbl_valid[i] && (oldest < 0 || tbl_rank[i] > tbl_rank[oldest]))
                            oldest = i;
                    end
                    if (oldest >= 0) begin
                        res.evicted       = 1'b1;
                        res.ev_range      = tbl_range[oldest];
                        tbl_valid[oldest] = 1'b0;
                        tbl_hot[oldest]   = 1'b0;
                        tbl_rank[oldest]  = 0;
                        if (tbl_count > 0) tbl_count--;
                    end
                end
                free_slot = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!tbl_valid[i]) begin
                        if (free_slot < 0) free_slot = i;
                    end else begin
                        tbl_rank[i]++;
                    end
                end
                if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_hot[free_slot]   = 1'b0;
                    tbl_range[free_slot] = rng;
                    tbl_rank[free_slot]  = 0;
                    tbl_count++;
                    res.temp = TEMP_WARM;
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endtask

    // Present one request, wait for acceptance, queue its expected result
    task automatic issue_request(input logic cmd, input logic [31:0] rng,
                                 input logic typed, input temp_result_t typed_exp);
        temp_result_t exp;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rng;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        exp = compute_temperature(cmd, rng);
        expected_temps.push_back(typed ? typed_exp : exp);
    endtask

    // Drain, then write max_size and read it back over APB
    task automatic apply_max_size(input logic [6:0] value);
        logic [31:0] word;
        i_s_tvalid <= 1'b0;
        while (expected_temps.size() != 0) @(posedge i_clk);
        word      = $urandom();
        word[6:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_SIZE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        max_size_q = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[6:0] !== value)
            note_mismatch($sformatf("max_size readback exp %0d got %0d", value, prdata[6:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        temp_result_t exp;
        temp_result_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = temp_result_t'(o_m_tdata[35:0]);
            if (expected_temps.size() == 0) begin
                note_mismatch($sformatf("result with no request pending: %h", o_m_tdata));
            end else begin
                exp = expected_temps.pop_front();
                if (got.temp !== exp.temp || got.was_present !== exp.was_present ||
                    got.evicted !== exp.evicted || got.ev_range !== exp.ev_range ||
                    o_m_tdata[39:36] !== 4'h0)
                    note_mismatch($sformatf(
                        "exp temp %0d present %0d evicted %0d range %h, got temp %0d present %0d evicted %0d range %h pad %h",
                        exp.temp, exp.was_present, exp.evicted, exp.ev_range,
                        got.temp, got.was_present, got.evicted, got.ev_range,
                        o_m_tdata[39:36]));
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_range_temperature_table_unit verification failed");
            $finish;
        end
    end

    initial begin
        int         n_items;
        int         eff;
        logic [6:0] lim_val;
        logic       cmd;
        logic [31:0] rng;
        mismatch_count = 0;
        idle_cycles    = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        tbl_count      = 0;
        max_size_q     = MAX_SIZE_RST;
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_hot[i]   = 1'b0;
            tbl_rank[i]  = 0;
            tbl_range[i] = '0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG)
                apply_max_size(DIRECTED[r].cfg);
            else
                issue_request(DIRECTED[r].cmd, DIRECTED[r].rng,
                              DIRECTED[r].typed, DIRECTED[r].exp);
        end

        // Random phases: one limit and one idling pattern each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       lim_val = 7'd64;
                1:       lim_val = 7'd3;
                2:       lim_val = 7'd0;
                3:       lim_val = 7'd127;
                4:       lim_val = 7'd1;
                5:       lim_val = 7'($urandom_range(63, 2));
                6:       lim_val = 7'd64;
                default: lim_val = 7'd100;
            endcase
            apply_max_size(lim_val);
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            eff = (lim_val > CAPACITY) ? CAPACITY : int'(lim_val);
            // pool a bit larger than the limit so hits and evictions mix
            range_pool.delete();
            for (int k = 0; k < eff + eff / 4 + 3; k++) range_pool.push_back($urandom());
            n_items = (eff >= 32) ? 110 : 55;
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(99) < 8)
                    rng = $urandom();
                else
                    rng = range_pool[$urandom_range(range_pool.size() - 1)];
                cmd = ($urandom_range(99) < 75) ? CMD_RAISE : CMD_QUERY;
                issue_request(cmd, rng, 1'b0, '0);
            end
        end

        // Drain and settle
        i_s_tvalid <= 1'b0;
        while (expected_temps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_temps.size() == 0) begin
            $display("lru_range_temperature_table_unit verification clean");
        end else begin
            $display("lru_range_temperature_table_unit verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/lrt_pkg.sv
sv/lrt_cfg.sv
sv/lrt_entry.sv
sv/lru_range_temperature_table_unit.sv
bench/tb_lru_range_temperature_table_unit.sv
